// ===== src/dps_pkg.sv =====
// Package for the decaying priority scheduler: sizes, command codes, state
// enum and the struct passed along the chain of slot cells. No dependencies.
`default_nettype none
package dps_pkg;
  localparam int unsigned Slots = 64;
  localparam int unsigned IdxW = $clog2(Slots);

  typedef enum logic [0:0] {
    CMD_YIELD = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AGE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Running best candidate handed from one cell to the next.
  typedef struct packed {
    logic            have;
    logic [IdxW-1:0] idx;
    logic [7:0]      prio;
  } best_t;

  function automatic logic [7:0] bump(input logic [7:0] c);
    bump = (c == 8'hff) ? c : c + 8'd1;
  endfunction
endpackage
`default_nettype wire

// ===== src/dps_cell.sv =====
// One slot of the scheduler table: list bit, priority word, runnable bit and
// counter. Depends on dps_pkg.
`default_nettype none
module dps_cell (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr_en,
  input  wire logic                     wr_present,
  input  wire logic [31:0]              wr_word,
  input  wire logic                     wr_runnable,
  input  wire logic                     age_en,
  input  wire logic                     scan_en,
  input  wire logic                     is_cur,
  input  wire logic [dps_pkg::IdxW-1:0] my_idx,
  input  wire dps_pkg::best_t           best_in,
  output dps_pkg::best_t                best_out
);
  logic        in_list_r;
  logic [31:0] word_r;
  logic        run_r;
  logic [7:0]  cnt_r;
  logic [7:0]  p_dec;
  logic [7:0]  c_inc;
  logic        wake;

  always_comb begin
    p_dec = (word_r[7:0] > word_r[15:8]) ? word_r[7:0] - word_r[15:8] : 8'd0;
    c_inc = dps_pkg::bump(cnt_r);
    wake  = in_list_r && !is_cur && !run_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_list_r <= 1'b0;
      cnt_r     <= 8'd0;
    end else if (wr_en) begin
      in_list_r <= wr_present;
      if (wr_present) begin
        word_r <= wr_word;
        run_r  <= wr_runnable;
        cnt_r  <= 8'd0;
      end
    end else if (age_en) begin
      word_r[7:0] <= p_dec;
      if (c_inc == word_r[23:16]) begin
        cnt_r <= 8'd0;
        if (word_r[31:24] != 8'd0) run_r <= 1'b0;
      end else begin
        cnt_r <= c_inc;
      end
    end else if (scan_en && wake) begin
      if (c_inc == word_r[31:24]) begin
        cnt_r <= 8'd0;
        run_r <= 1'b1;
      end else begin
        cnt_r <= c_inc;
      end
    end
  end

  // Selection sees the runnable bit after this yield's wake update.
  logic run_eff;
  always_comb begin
    run_eff = run_r || (wake && c_inc == word_r[31:24]);
    best_out = best_in;
    if (in_list_r && run_eff && (!best_in.have || word_r[7:0] > best_in.prio)) begin
      best_out.have = 1'b1;
      best_out.idx  = my_idx;
      best_out.prio = word_r[7:0];
    end
  end
endmodule
`default_nettype wire

// ===== src/decaying_priority_scheduler.sv =====
// Top level of the decaying priority scheduler: control sequencer and the row
// of dps_cell slots. Depends on dps_pkg and dps_cell.
//
// channel | ports                                 | handshake
// input   | in_command .. in_start_runnable       | start && !busy
// result  | out_found, out_chosen_index/_priority | out_valid, one cycle
//
// A write updates its slot when accepted. A yield first ages the current task,
// then a token walks the chain of cells slot by slot carrying the best
// candidate, and finally the result is presented.
// Reset clears list bits, counters and the current task. The receiver cannot
// stall; busy holds off new items while a yield is in progress.
`default_nettype none
module decaying_priority_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_command,
  input  wire logic [5:0]  in_entry_index,
  input  wire logic        in_entry_present,
  input  wire logic [31:0] in_priority_word,
  input  wire logic        in_start_runnable,
  output logic             out_valid,
  output logic             out_found,
  output logic [5:0]       out_chosen_index,
  output logic [7:0]       out_chosen_priority
);
  localparam int unsigned N = dps_pkg::Slots;
  localparam int unsigned W = dps_pkg::IdxW;

  dps_pkg::state_t state_r, state_nxt;
  logic [W-1:0]    pos_r, pos_nxt;
  logic [W-1:0]    cur_r;
  logic            cur_v_r;
  dps_pkg::best_t  best_r, best_nxt;
  dps_pkg::best_t  chain [N];
  logic            accept;

  assign accept = start && !busy;
  assign busy   = (state_r != dps_pkg::ST_IDLE);

  // The token for position pos_r enters cell pos_r; its output is registered.
  for (genvar g = 0; g < N; g++) begin : g_cell
    dps_pkg::best_t bin;
    assign bin = best_r;
    dps_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .wr_en      (accept && in_command == dps_pkg::CMD_WRITE &&
                   in_entry_index == W'(g)),
      .wr_present (in_entry_present),
      .wr_word    (in_priority_word),
      .wr_runnable(in_start_runnable),
      .age_en     (state_r == dps_pkg::ST_AGE && cur_v_r && cur_r == W'(g)),
      .scan_en    (state_r == dps_pkg::ST_SCAN && pos_r == W'(g)),
      .is_cur     (cur_v_r && cur_r == W'(g)),
      .my_idx     (W'(g)),
      .best_in    (bin),
      .best_out   (chain[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dps_pkg::ST_IDLE;
      pos_r   <= '0;
      best_r  <= '0;
      cur_r   <= '0;
      cur_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      best_r  <= best_nxt;
      if (state_r == dps_pkg::ST_DONE && best_r.have) begin
        cur_r   <= best_r.idx;
        cur_v_r <= 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    best_nxt  = best_r;
    out_valid = 1'b0;
    out_found = 1'b0;
    out_chosen_index    = '0;
    out_chosen_priority = '0;
    unique case (state_r)
      dps_pkg::ST_IDLE: begin
        if (accept && in_command == dps_pkg::CMD_YIELD) begin
          state_nxt = dps_pkg::ST_AGE;
        end
      end
      dps_pkg::ST_AGE: begin
        pos_nxt   = '0;
        best_nxt  = '0;
        state_nxt = dps_pkg::ST_SCAN;
      end
      dps_pkg::ST_SCAN: begin
        best_nxt = chain[pos_r];
        pos_nxt  = pos_r + W'(1);
        if (pos_r == W'(N-1)) state_nxt = dps_pkg::ST_DONE;
      end
      dps_pkg::ST_DONE: begin
        out_valid = 1'b1;
        out_found = best_r.have;
        if (best_r.have) begin
          out_chosen_index    = 6'(best_r.idx);
          out_chosen_priority = best_r.prio;
        end
        state_nxt = dps_pkg::ST_IDLE;
      end
      default: state_nxt = dps_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== tb/decaying_priority_scheduler_tb.sv =====
// Testbench for decaying_priority_scheduler: drives write and yield items,
// predicts each yield result from a behavioral copy of the slot table and checks
// it field by field. Depends on dps_pkg and the scheduler RTL.
`default_nettype none
module decaying_priority_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumSlots = 64;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic       found;
    logic [5:0] idx;
    logic [7:0] prio;
  } pick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = 1'b0;
  logic [5:0] in_entry_index = '0;
  logic in_entry_present = 1'b0;
  logic [31:0] in_priority_word = '0;
  logic in_start_runnable = 1'b0;
  logic out_valid, out_found;
  logic [5:0] out_chosen_index;
  logic [7:0] out_chosen_priority;

  logic        tbl_listed [NumSlots];
  logic [31:0] tbl_word [NumSlots];
  logic        tbl_runnable [NumSlots];
  logic [7:0]  tbl_count [NumSlots];
  logic [5:0]  cur_slot;
  logic        cur_valid;

  pick_t expected_picks[$];
  int errors = 0;
  int idle_cycles = 0;

  decaying_priority_scheduler uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] sat_inc(input logic [7:0] c);
    return (c == 8'hff) ? c : c + 8'd1;
  endfunction

  // Applies one item to the table copy and queues the result of a yield.
  function automatic void schedule_model(input dps_pkg::cmd_t cmd, input logic [5:0] idx,
                                         input logic present, input logic [31:0] w,
                                         input logic run);
    pick_t p;
    logic [7:0] pr, dc;
    int best;
    bit have;
    p = '0;
    best = 0;
    have = 0;
    if (cmd == dps_pkg::CMD_WRITE) begin
      if (present) begin
        tbl_listed[idx] = 1'b1;
        tbl_word[idx] = w;
        tbl_runnable[idx] = run;
        tbl_count[idx] = '0;
      end else begin
        tbl_listed[idx] = 1'b0;
      end
      return;
    end
    if (cur_valid) begin
      pr = tbl_word[cur_slot][7:0];
      dc = tbl_word[cur_slot][15:8];
      tbl_word[cur_slot][7:0] = (pr > dc) ? pr - dc : 8'd0;
      tbl_count[cur_slot] = sat_inc(tbl_count[cur_slot]);
      if (tbl_count[cur_slot] == tbl_word[cur_slot][23:16]) begin
        tbl_count[cur_slot] = '0;
        if (tbl_word[cur_slot][31:24] != 0) tbl_runnable[cur_slot] = 1'b0;
      end
    end
    for (int i = 0; i < NumSlots; i++) begin
      if (!tbl_listed[i]) continue;
      if (!(cur_valid && i == cur_slot) && !tbl_runnable[i]) begin
        tbl_count[i] = sat_inc(tbl_count[i]);
        if (tbl_count[i] == tbl_word[i][31:24]) begin
          tbl_count[i] = '0;
          tbl_runnable[i] = 1'b1;
        end
      end
      if (tbl_runnable[i] && (!have || tbl_word[i][7:0] > tbl_word[best][7:0])) begin
        best = i;
        have = 1;
      end
    end
    if (have) begin
      cur_slot = best[5:0];
      cur_valid = 1'b1;
      p.found = 1'b1;
      p.idx = best[5:0];
      p.prio = tbl_word[best][7:0];
    end
    expected_picks.push_back(p);
  endfunction

  // Start stays high after an accept so that a back-to-back item is driven
  // with a single assignment in that time step; a gap or a drain drops it.
  task automatic send_item(input dps_pkg::cmd_t cmd, input logic [5:0] idx,
                           input logic present, input logic [31:0] w, input logic run,
                           input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_entry_index <= idx;
    in_entry_present <= present;
    in_priority_word <= w;
    in_start_runnable <= run;
    do @(posedge clk); while (busy);
    // The current cycle's edge accepted the item; the model is kept in step.
    schedule_model(cmd, idx, present, w, run);
  endtask

  task automatic write_slot(input logic [5:0] idx, input logic [31:0] w, input logic run,
                            input int gap = 0);
    send_item(dps_pkg::CMD_WRITE, idx, 1'b1, w, run, gap);
  endtask

  task automatic remove_slot(input logic [5:0] idx, input int gap = 0);
    send_item(dps_pkg::CMD_WRITE, idx, 1'b0, $urandom, 1'($urandom_range(0, 1)), gap);
  endtask

  task automatic yield_once(input int gap = 0);
    // Write fields are ignored on a yield, so they carry noise.
    send_item(dps_pkg::CMD_YIELD, 6'($urandom), 1'($urandom_range(0, 1)), $urandom,
              1'($urandom_range(0, 1)), gap);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    pick_t e;
    if (rst_n && out_valid) begin
      if (expected_picks.size() == 0) begin
        $error("unexpected result: found=%0d index=%0d priority=%0d",
               out_found, out_chosen_index, out_chosen_priority);
        errors++;
      end else begin
        e = expected_picks.pop_front();
        if (out_found !== e.found) begin
          $error("found: expected %0d, got %0d", e.found, out_found);
          errors++;
        end
        if (out_chosen_index !== e.idx) begin
          $error("chosen_index: expected %0d, got %0d", e.idx, out_chosen_index);
          errors++;
        end
        if (out_chosen_priority !== e.prio) begin
          $error("chosen_priority: expected %0d, got %0d", e.prio, out_chosen_priority);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_empty_table();
    yield_once();
    yield_once(3);
  endtask

  task automatic test_extremes();
    write_slot(6'd0, 32'h0000_00ff, 1'b1);
    write_slot(6'd63, 32'hffff_ffff, 1'b1);
    yield_once();
    yield_once();
    write_slot(6'd63, 32'h0000_0000, 1'b0);
    write_slot(6'd32, 32'h0201_0380, 1'b0);
    repeat (4) yield_once();
    // Slots 5 and 9 tie on priority (a tie goes to the lower slot), but slot 0 outranks both.
    write_slot(6'd5, 32'h0000_0040, 1'b1);
    write_slot(6'd9, 32'h0000_0040, 1'b1);
    yield_once();
    remove_slot(6'd5);
    remove_slot(6'd9);
    yield_once();
  endtask

  task automatic test_decay_and_sleep();
    // Sleep length zero never wakes; run limit zero never sends the task asleep.
    write_slot(6'd10, 32'h0000_0590, 1'b1);
    write_slot(6'd11, 32'h0000_0000, 1'b0);
    write_slot(6'd12, 32'h0302_0150, 1'b1);
    repeat (8) yield_once($urandom_range(0, 2));
    remove_slot(6'd0);
    remove_slot(6'd10);
    remove_slot(6'd12);
    yield_once();
    drain();
  endtask

  task automatic test_random(input int n);
    int gap;
    logic [5:0] idx;
    for (int k = 0; k < n; k++) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (k % 300 < 40) gap = 0;
      if (k == n / 2) drain();
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          idx = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
          write_slot(idx, {$urandom_range(0, 1) ? 8'($urandom_range(0, 6)) : 8'($urandom),
                           8'($urandom_range(0, 5)), 8'($urandom_range(0, 8)),
                           $urandom_range(0, 1) ? 8'($urandom_range(0, 9)) : 8'($urandom)},
                     1'($urandom_range(0, 1)), gap);
        end
        3: begin
          idx = 6'($urandom_range(0, 63));
          // Removal of a slot never written is safe: it only clears the list bit.
          remove_slot(idx, gap);
        end
        default: yield_once(gap);
      endcase
    end
  endtask

  initial begin
    foreach (tbl_listed[i]) begin
      tbl_listed[i] = 0;
      tbl_word[i] = 0;
      tbl_runnable[i] = 0;
      tbl_count[i] = 0;
    end
    cur_slot = 0;
    cur_valid = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_extremes();
    test_decay_and_sleep();
    test_random(1800);
    drain();
    repeat (80) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
